>>> rtl/core/vlmq_pkg.sv
// ----------------------------------------------------------------------------
// vlmq_pkg
// Shared constants and codes for the variable length message queue.
// ----------------------------------------------------------------------------
package vlmq_pkg;

   localparam int MAX_BLOCKS        = 64;
   localparam int MAX_BLOCK_BYTES   = 64;
   localparam int MAX_MESSAGE_BYTES = 256;
   localparam int HEADER_BYTES      = 4;
   localparam int STORE_BYTES       = MAX_BLOCKS * MAX_BLOCK_BYTES + MAX_MESSAGE_BYTES
                                      + HEADER_BYTES;
   localparam int ADDR_W            = $clog2(STORE_BYTES);

   typedef logic [ADDR_W-1:0] addr_type;

   localparam logic [2:0] STAT_OK      = 3'd0;
   localparam logic [2:0] STAT_FULL    = 3'd1;
   localparam logic [2:0] STAT_EMPTY   = 3'd2;
   localparam logic [2:0] STAT_BADCFG  = 3'd3;
   localparam logic [2:0] STAT_BUSY    = 3'd4;
   localparam logic [2:0] STAT_TOOLONG = 3'd5;

   localparam logic [1:0] MODE_HEADER = 2'd0;
   localparam logic [1:0] MODE_DATA   = 2'd1;
   localparam logic [1:0] MODE_GET    = 2'd2;

   localparam logic       CSR_BLOCK_BYTES = 1'b0;
   localparam logic       CSR_BLOCK_COUNT = 1'b1;

   localparam logic [6:0] COUNT_MAX = 7'd127;

endpackage

>>> rtl/core/variable_length_message_queue.sv
// ----------------------------------------------------------------------------
// variable_length_message_queue
// Message FIFO over a block-divided byte store with a length header.
// ----------------------------------------------------------------------------
// The block works on one word at a time and moves one store byte per cycle,
// while a write or read is under way, through a single byte-wide memory with
// a registered read. A header word runs a serial divide for the block count,
// then writes four header bytes; a data word writes its payload bytes; and a
// get reads the header bytes and divides for the block count, then reads the
// bytes of each returned word. The byte port of the store sets this pace.
module variable_length_message_queue (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [79:0] req_tdata,   // msg_length[8:0], data_word[72:9], zeros
   input  logic [1:0]  req_tuser,   // mode[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [87:0] rsp_tdata,   // msg_length_res[8:0], data_word_res[72:9],
                                    // used_blocks[79:73], msg_count[86:80], zero
   output logic [2:0]  rsp_tuser,   // status[2:0]
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [6:0]  csr_wdata
);
   import vlmq_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_DIVA, S_WR, S_RD, S_DIVG, S_EMIT
   } state_type;

   state_type  state_ff;
   logic [6:0] bb_ff, bc_ff;
   logic [6:0] wb_ff, rb_ff, used_ff, total_ff;
   logic [5:0] pend_ff;
   addr_type   fill_ff;
   logic [2:0] tail_ff;
   logic [8:0] len_ff;
   logic [63:0] wbuf_ff;
   addr_type   wr_addr_ff;
   logic [3:0] wr_left_ff;
   addr_type   rd_addr_ff;
   logic [3:0] rd_left_ff, cap_left_ff;
   logic       rdv_ff, rd_ok_ff, rd_hdr_ff;
   logic [8:0] off_ff;
   logic [63:0] acc_ff;
   logic [5:0] words_left_ff;
   logic [2:0] res_status_ff;
   logic [8:0] res_len_ff;
   logic       res_last_ff;
   logic       div_start_ff;
   logic [8:0] div_dvd_ff;
   logic       rsp_tvalid_ff, rsp_tlast_ff;
   logic [87:0] rsp_tdata_ff;
   logic [2:0] rsp_tuser_ff;

   logic       div_done;
   logic [8:0] div_q;
   logic       mem_we;
   logic [7:0] mem_q;
   logic       slot_free;
   logic       issue;
   logic [13:0] wb_prod, rb_prod;
   logic [8:0] in_len;
   logic [9:0] need;
   logic [9:0] adv_w, adv_r;
   logic [7:0] byte_in;
   logic [31:0] hdr_word;
   logic [8:0] glen;
   logic [9:0] get_dvd;
   logic [3:0] nbytes;
   logic [9:0] plen7;

   vlmq_store u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (wr_addr_ff),
      .wr_data (wbuf_ff[7:0]),
      .rd_addr (rd_addr_ff),
      .rd_data (mem_q)
   );

   vlmq_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend (div_dvd_ff),
      .divisor  (bb_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   assign slot_free = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign mem_we = (state_ff == S_WR) && (32'(wr_addr_ff) < STORE_BYTES);
   assign issue = (state_ff == S_RD) && (rd_left_ff != 4'd0);
   assign wb_prod = wb_ff * bb_ff;
   assign rb_prod = rb_ff * bb_ff;
   assign in_len = req_tdata[8:0];
   assign need = {3'b0, used_ff} + {1'b0, div_q};
   assign adv_w = {3'b0, wb_ff} + {1'b0, div_q};
   assign adv_r = {3'b0, rb_ff} + {1'b0, div_q};
   assign byte_in = rd_ok_ff ? mem_q : 8'd0;
   assign hdr_word = {byte_in, acc_ff[63:40]};
   assign glen = (hdr_word > 32'(MAX_MESSAGE_BYTES)) ? 9'(MAX_MESSAGE_BYTES)
                                                     : hdr_word[8:0];
   assign get_dvd = {1'b0, glen} + 10'(HEADER_BYTES) + {3'b0, bb_ff} - 10'd1;
   assign nbytes = (pend_ff == 6'd1 && tail_ff != 3'd0) ? {1'b0, tail_ff} : 4'd8;
   assign plen7 = {1'b0, len_ff} + 10'd7;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         bb_ff         <= 7'd16;
         bc_ff         <= 7'd64;
         wb_ff         <= '0;
         rb_ff         <= '0;
         used_ff       <= '0;
         total_ff      <= '0;
         pend_ff       <= '0;
         fill_ff       <= '0;
         tail_ff       <= '0;
         rdv_ff        <= 1'b0;
         div_start_ff  <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rdv_ff <= issue;
         if (rsp_tready && state_ff != S_EMIT) begin
            rsp_tvalid_ff <= 1'b0;
         end
         if (csr_we) begin
            case (csr_index)
               CSR_BLOCK_BYTES: bb_ff <= (csr_wdata > 7'(MAX_BLOCK_BYTES))
                                         ? 7'(MAX_BLOCK_BYTES) : csr_wdata;
               CSR_BLOCK_COUNT: bc_ff <= (csr_wdata > 7'(MAX_BLOCKS))
                                         ? 7'(MAX_BLOCKS) : csr_wdata;
               default: ;
            endcase
         end
         if (issue) begin
            rd_ok_ff   <= (32'(rd_addr_ff) < STORE_BYTES) && (rd_hdr_ff || off_ff < len_ff);
            rd_addr_ff <= rd_addr_ff + addr_type'(1);
            rd_left_ff <= rd_left_ff - 4'd1;
            if (!rd_hdr_ff) begin
               off_ff <= off_ff + 9'd1;
            end
         end
         case (state_ff)
            S_IDLE: begin
               res_len_ff  <= '0;
               res_last_ff <= 1'b1;
               acc_ff      <= '0;
               if (req_tvalid) begin
                  len_ff <= in_len;
                  case (req_tuser)
                     MODE_HEADER: begin
                        state_ff <= S_EMIT;
                        if (bb_ff == 7'd0) begin
                           res_status_ff <= STAT_BADCFG;
                        end else if (pend_ff != 6'd0) begin
                           res_status_ff <= STAT_BUSY;
                        end else if (in_len > 9'(MAX_MESSAGE_BYTES)) begin
                           res_status_ff <= STAT_TOOLONG;
                        end else begin
                           state_ff <= S_DIVA;
                           div_start_ff <= 1'b1;
                           div_dvd_ff <= 9'({1'b0, in_len} + 10'(HEADER_BYTES)
                                            + {3'b0, bb_ff} - 10'd1);
                        end
                     end
                     MODE_DATA: begin
                        state_ff <= S_EMIT;
                        if (pend_ff == 6'd0) begin
                           res_status_ff <= STAT_EMPTY;
                        end else begin
                           res_status_ff <= STAT_OK;
                           wbuf_ff    <= req_tdata[72:9];
                           wr_addr_ff <= fill_ff;
                           wr_left_ff <= nbytes;
                           fill_ff    <= fill_ff + addr_type'(nbytes);
                           pend_ff    <= pend_ff - 6'd1;
                           state_ff   <= S_WR;
                        end
                     end
                     MODE_GET: begin
                        state_ff <= S_EMIT;
                        if (pend_ff != 6'd0) begin
                           res_status_ff <= STAT_BUSY;
                        end else if (total_ff == 7'd0) begin
                           res_status_ff <= STAT_EMPTY;
                        end else if (bb_ff == 7'd0) begin
                           res_status_ff <= STAT_BADCFG;
                        end else begin
                           res_status_ff <= STAT_OK;
                           rd_addr_ff  <= rb_prod[ADDR_W-1:0];
                           rd_left_ff  <= 4'(HEADER_BYTES);
                           cap_left_ff <= 4'(HEADER_BYTES);
                           rd_hdr_ff   <= 1'b1;
                           off_ff      <= '0;
                           state_ff    <= S_RD;
                        end
                     end
                     default: state_ff <= S_IDLE;
                  endcase
               end
            end
            S_DIVA: begin
               div_start_ff <= 1'b0;
               if (div_done) begin
                  state_ff <= S_EMIT;
                  if (need > {3'b0, bc_ff} || total_ff >= COUNT_MAX) begin
                     res_status_ff <= STAT_FULL;
                  end else begin
                     res_status_ff <= STAT_OK;
                     wr_addr_ff <= wb_prod[ADDR_W-1:0];
                     wbuf_ff    <= {55'd0, len_ff};
                     wr_left_ff <= 4'(HEADER_BYTES);
                     fill_ff    <= wb_prod[ADDR_W-1:0] + addr_type'(HEADER_BYTES);
                     pend_ff    <= plen7[8:3];
                     tail_ff    <= len_ff[2:0];
                     wb_ff      <= (adv_w > {3'b0, bc_ff}) ? 7'd0 : adv_w[6:0];
                     used_ff    <= need[6:0];
                     total_ff   <= total_ff + 7'd1;
                     state_ff   <= S_WR;
                  end
               end
            end
            S_WR: begin
               wr_addr_ff <= wr_addr_ff + addr_type'(1);
               wbuf_ff    <= {8'd0, wbuf_ff[63:8]};
               wr_left_ff <= wr_left_ff - 4'd1;
               if (wr_left_ff == 4'd1) begin
                  state_ff <= S_EMIT;
               end
            end
            S_RD: begin
               if (rdv_ff) begin
                  acc_ff      <= {byte_in, acc_ff[63:8]};
                  cap_left_ff <= cap_left_ff - 4'd1;
                  if (cap_left_ff == 4'd1) begin
                     if (rd_hdr_ff) begin
                        len_ff       <= glen;
                        div_dvd_ff   <= get_dvd[8:0];
                        div_start_ff <= 1'b1;
                        state_ff     <= S_DIVG;
                     end else begin
                        res_last_ff <= (words_left_ff == 6'd1);
                        state_ff    <= S_EMIT;
                     end
                  end
               end
            end
            S_DIVG: begin
               div_start_ff <= 1'b0;
               if (div_done) begin
                  rb_ff    <= (adv_r > {3'b0, bc_ff}) ? 7'd0 : adv_r[6:0];
                  used_ff  <= ({2'b0, used_ff} > div_q) ? 7'(9'(used_ff) - div_q) : 7'd0;
                  total_ff <= total_ff - 7'd1;
                  words_left_ff <= (len_ff == 9'd0) ? 6'd1 : plen7[8:3];
                  res_len_ff  <= len_ff;
                  rd_hdr_ff   <= 1'b0;
                  rd_left_ff  <= 4'd8;
                  cap_left_ff <= 4'd8;
                  state_ff    <= S_RD;
               end
            end
            S_EMIT: begin
               if (slot_free) begin
                  rsp_tvalid_ff <= 1'b1;
                  rsp_tuser_ff  <= res_status_ff;
                  rsp_tlast_ff  <= res_last_ff;
                  rsp_tdata_ff  <= {1'b0, total_ff, used_ff, acc_ff, res_len_ff};
                  if (res_last_ff) begin
                     state_ff <= S_IDLE;
                  end else begin
                     words_left_ff <= words_left_ff - 6'd1;
                     rd_left_ff    <= 4'd8;
                     cap_left_ff   <= 4'd8;
                     state_ff      <= S_RD;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;
   assign rsp_tlast  = rsp_tlast_ff;

endmodule

>>> rtl/core/vlmq_store.sv
// ----------------------------------------------------------------------------
// vlmq_store
// Byte-wide message store with one write port and one registered read port.
// ----------------------------------------------------------------------------
module vlmq_store (
   input  logic              clock,
   input  logic              wr_en,
   input  vlmq_pkg::addr_type wr_addr,
   input  logic [7:0]        wr_data,
   input  vlmq_pkg::addr_type rd_addr,
   output logic [7:0]        rd_data
);
   import vlmq_pkg::*;

   logic [7:0] mem [STORE_BYTES];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/vlmq_div.sv
// ----------------------------------------------------------------------------
// vlmq_div
// Restoring divider, one quotient bit per cycle, for block counts.
// ----------------------------------------------------------------------------
module vlmq_div (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic [8:0] dividend,
   input  logic [6:0] divisor,
   output logic       done,
   output logic [8:0] quotient
);
   logic       busy_ff, busy_in;
   logic       done_ff, done_in;
   logic [3:0] cnt_ff, cnt_in;
   logic [7:0] rem_ff, rem_in;
   logic [8:0] dvd_ff, dvd_in;
   logic [6:0] div_ff, div_in;
   logic [7:0] trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      div_in  = div_ff;
      trial   = {rem_ff[6:0], dvd_ff[8]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 4'd0;
         rem_in  = 8'd0;
         dvd_in  = dividend;
         div_in  = divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, div_ff}) begin
            rem_in = trial - {1'b0, div_ff};
            dvd_in = {dvd_ff[7:0], 1'b1};
         end else begin
            rem_in = trial;
            dvd_in = {dvd_ff[7:0], 1'b0};
         end
         cnt_in = cnt_ff + 4'd1;
         if (cnt_ff == 4'd8) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      div_ff <= div_in;
   end

   assign done     = done_ff;
   assign quotient = dvd_ff;

endmodule

>>> tb/variable_length_message_queue_checker.sv
// ----------------------------------------------------------------------------
// variable_length_message_queue_checker
// Watches the request, response and register ports of the message queue. It
// keeps its own copy of the byte store and the queue pointers, works out the
// response words of every accepted request word and compares them in order.
// ----------------------------------------------------------------------------
module variable_length_message_queue_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [79:0] req_tdata,
   input  logic [1:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [87:0] rsp_tdata,
   input  logic [2:0]  rsp_tuser,
   input  logic        rsp_tlast,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [6:0]  csr_wdata,
   output int          fail_count,
   output int          outstanding,
   output int          queued_msgs,
   output int          owed_words
);
   import vlmq_pkg::*;

   typedef struct {
      logic [2:0]  status;
      logic [8:0]  length;
      logic [63:0] payload;
      logic        last;
      logic [6:0]  used;
      logic [6:0]  count;
   } reply_type;

   reply_type   replies[$];
   logic [7:0]  bytes_mem[STORE_BYTES];
   int unsigned wr_block, rd_block, used_blocks, msg_total;
   int unsigned words_left, fill_ptr, tail_bytes;
   int unsigned blk_bytes, blk_count;

   function automatic int unsigned blocks_needed(int unsigned len);
      return (len + HEADER_BYTES + blk_bytes - 1) / blk_bytes;
   endfunction

   function automatic int unsigned next_block(int unsigned pos, int unsigned n);
      return (pos + n > blk_count) ? 0 : pos + n;
   endfunction

   function automatic void store_byte(int unsigned a, logic [7:0] v);
      if (a < STORE_BYTES) bytes_mem[a] = v;
   endfunction

   function automatic logic [7:0] load_byte(int unsigned a);
      return (a < STORE_BYTES) ? bytes_mem[a] : 8'd0;
   endfunction

   function automatic void push_reply(logic [2:0] st, int unsigned len,
                                      logic [63:0] w, logic lst);
      reply_type r;
      r.status  = st;
      r.length  = len[8:0];
      r.payload = w;
      r.last    = lst;
      r.used    = used_blocks[6:0];
      r.count   = msg_total[6:0];
      replies.push_back(r);
   endfunction

   function automatic void predict(logic [1:0] mode, int unsigned len, logic [63:0] w);
      int unsigned n, base, words;
      logic [63:0] acc;
      case (mode)
         MODE_HEADER: begin
            if (blk_bytes == 0) push_reply(STAT_BADCFG, 0, 0, 1);
            else if (words_left != 0) push_reply(STAT_BUSY, 0, 0, 1);
            else if (len > MAX_MESSAGE_BYTES) push_reply(STAT_TOOLONG, 0, 0, 1);
            else begin
               n = blocks_needed(len);
               if (used_blocks + n > blk_count || msg_total >= COUNT_MAX) begin
                  push_reply(STAT_FULL, 0, 0, 1);
               end else begin
                  base = wr_block * blk_bytes;
                  for (int i = 0; i < HEADER_BYTES; i++)
                     store_byte(base + i, 8'(len >> (8 * i)));
                  fill_ptr = (base + HEADER_BYTES) & 13'h1fff;
                  words_left = (len + 7) / 8;
                  tail_bytes = len & 7;
                  wr_block = next_block(wr_block, n);
                  used_blocks += n;
                  msg_total += 1;
                  push_reply(STAT_OK, 0, 0, 1);
               end
            end
         end
         MODE_DATA: begin
            if (words_left == 0) begin
               push_reply(STAT_EMPTY, 0, 0, 1);
            end else begin
               n = (words_left == 1 && tail_bytes != 0) ? tail_bytes : 8;
               for (int i = 0; i < n; i++) store_byte(fill_ptr + i, 8'(w >> (8 * i)));
               fill_ptr = (fill_ptr + n) & 13'h1fff;
               words_left -= 1;
               push_reply(STAT_OK, 0, 0, 1);
            end
         end
         MODE_GET: begin
            if (words_left != 0) push_reply(STAT_BUSY, 0, 0, 1);
            else if (msg_total == 0) push_reply(STAT_EMPTY, 0, 0, 1);
            else if (blk_bytes == 0) push_reply(STAT_BADCFG, 0, 0, 1);
            else begin
               base = rd_block * blk_bytes;
               len = 0;
               for (int i = 0; i < HEADER_BYTES; i++) len |= load_byte(base + i) << (8 * i);
               if (len > MAX_MESSAGE_BYTES) len = MAX_MESSAGE_BYTES;
               n = blocks_needed(len);
               rd_block = next_block(rd_block, n);
               used_blocks = (used_blocks > n) ? used_blocks - n : 0;
               msg_total -= 1;
               words = (len == 0) ? 1 : (len + 7) / 8;
               for (int k = 0; k < words; k++) begin
                  acc = 0;
                  for (int i = 0; i < 8; i++)
                     if (k * 8 + i < len)
                        acc |= 64'(load_byte(base + HEADER_BYTES + k * 8 + i)) << (8 * i);
                  push_reply(STAT_OK, len, acc, k + 1 == words);
               end
            end
         end
         default: ;
      endcase
   endfunction

   function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         fail_count++;
      end
   endfunction

   initial fail_count = 0;

   always @(posedge clock) begin
      reply_type r;
      if (reset) begin
         replies.delete();
         foreach (bytes_mem[i]) bytes_mem[i] = 8'd0;
         wr_block = 0; rd_block = 0; used_blocks = 0; msg_total = 0;
         words_left = 0; fill_ptr = 0; tail_bytes = 0;
         blk_bytes = 16; blk_count = 64;
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_BLOCK_BYTES)
               blk_bytes = (csr_wdata > MAX_BLOCK_BYTES) ? MAX_BLOCK_BYTES : csr_wdata;
            else
               blk_count = (csr_wdata > MAX_BLOCKS) ? MAX_BLOCKS : csr_wdata;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (replies.size() == 0) begin
               $error("response word with no request waiting for it");
               fail_count++;
            end else begin
               r = replies.pop_front();
               check_field("status", r.status, rsp_tuser);
               check_field("msg_length_res", r.length, rsp_tdata[8:0]);
               check_field("data_word_res", r.payload, rsp_tdata[72:9]);
               check_field("last", r.last, rsp_tlast);
               check_field("used_blocks", r.used, rsp_tdata[79:73]);
               check_field("msg_count", r.count, rsp_tdata[86:80]);
            end
         end
         if (req_tvalid && req_tready)
            predict(req_tuser, req_tdata[8:0], req_tdata[72:9]);
      end
      outstanding <= replies.size();
      queued_msgs <= msg_total;
      owed_words  <= words_left;
   end

endmodule

>>> tb/variable_length_message_queue_test.sv
// ----------------------------------------------------------------------------
// variable_length_message_queue_test
// Drives directed and random request words into the message queue under
// several block geometries, with random stalls on both sides, and reports the
// verdict of the checker.
// ----------------------------------------------------------------------------
module variable_length_message_queue_test;
   import vlmq_pkg::*;

   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam int         CYCLE_LIMIT = 2000000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [79:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [87:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_we = 1'b0;
   logic        csr_index = 1'b0;
   logic [6:0]  csr_wdata = '0;

   int fail_count, outstanding, queued_msgs, owed_words;
   int cycles = 0;
   int hold_left = 0;
   bit hold_go = 0;
   bit calm = 0;

   always #10 clock = ~clock;

   variable_length_message_queue u_dut (.*);

   variable_length_message_queue_checker u_checker (.*);

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("variable_length_message_queue: mismatch");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (hold_go) begin
         hold_go = 0;
         hold_left = 400;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= calm ? 1'b1 : ($urandom_range(99) >= 30);
      end
   end

   task automatic send(logic [1:0] mode, logic [8:0] len, logic [63:0] w);
      while (!calm && $urandom_range(99) < 30) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {7'd0, w, len};
      do @(posedge clock); while (!req_tready);
   endtask

   function automatic logic [63:0] any_word();
      return {$urandom, $urandom};
   endfunction

   task automatic add_message(int len);
      send(MODE_HEADER, 9'(len), any_word());
      for (int k = 0; k < (len + 7) / 8; k++) send(MODE_DATA, 0, any_word());
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic drain();
      settle();
      while (owed_words > 0) begin
         send(MODE_DATA, 0, any_word());
         settle();
      end
      while (queued_msgs > 0) begin
         send(MODE_GET, 0, 0);
         settle();
      end
   endtask

   task automatic write_reg(logic idx, logic [6:0] val);
      settle();
      repeat (40) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic random_items(int total);
      int sent = 0;
      int r, len;
      while (sent < total) begin
         r = $urandom_range(99);
         if (r < 45) begin
            r = $urandom_range(99);
            len = (r < 85) ? $urandom_range(40) : (r < 95) ? $urandom_range(256, 41) : 256;
            add_message(len);
            sent += 1 + (len + 7) / 8;
         end else if (r < 80) begin
            send(MODE_GET, 9'($urandom), any_word());
            sent++;
         end else if (r < 85) begin
            send(MODE_UNUSED, 9'($urandom), any_word());
         end else if (r < 90) begin
            send(MODE_HEADER, 9'($urandom_range(511, 257)), any_word());
            sent++;
         end else if (r < 95) begin
            send(MODE_DATA, 9'($urandom), any_word());
            sent++;
         end else begin
            len = $urandom_range(64, 9);
            send(MODE_HEADER, 9'(len), any_word());
            send(MODE_HEADER, 9'($urandom_range(20)), any_word());
            send(MODE_GET, 0, 0);
            for (int k = 0; k < (len + 7) / 8; k++) send(MODE_DATA, 0, any_word());
            sent += 3 + (len + 7) / 8;
         end
      end
   endtask

   task automatic phase(logic [6:0] bytes_per_block, logic [6:0] blocks, int total);
      drain();
      write_reg(CSR_BLOCK_BYTES, bytes_per_block);
      write_reg(CSR_BLOCK_COUNT, blocks);
      random_items(total);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send(MODE_GET, 0, 0);
      send(MODE_DATA, 0, '1);
      send(MODE_UNUSED, 9'h1ff, '1);
      add_message(0);
      send(MODE_HEADER, 256, 0);
      send(MODE_GET, 0, 0);
      send(MODE_HEADER, 5, 0);
      for (int k = 0; k < 32; k++) send(MODE_DATA, 0, (k[0]) ? '1 : 64'h0);
      send(MODE_HEADER, 257, 0);
      send(MODE_HEADER, 511, '1);
      send(MODE_GET, 0, 0);
      send(MODE_GET, 0, 0);
      add_message(3);
      send(MODE_HEADER, 252, 0);
      drain();
      add_message(7);
      write_reg(CSR_BLOCK_BYTES, 0);
      send(MODE_GET, 0, 0);
      send(MODE_HEADER, 1, 0);
      write_reg(CSR_BLOCK_BYTES, 16);

      drain();
      hold_go = 1;
      random_items(20);
      drain();
      calm = 1;
      random_items(15);
      calm = 0;
      phase(64, 64, 20);
      phase(1, 64, 15);
      phase(127, 1, 12);
      phase(8, 0, 8);
      phase(0, 64, 8);
      phase(127, 127, 25);
      phase(16, 64, 12);

      settle();
      repeat (200) @(posedge clock);
      if (fail_count == 0 && outstanding == 0)
         $display("variable_length_message_queue: match");
      else
         $display("variable_length_message_queue: mismatch");
      $finish;
   end

endmodule
